FILE: rtl/sps_pkg.sv
// Shared types and constants for the scale packet settle latch.
// Used by every module in rtl/; depends on nothing else.
package sps_pkg;

  localparam logic [7:0]  MAGIC_VALUE   = 8'hAC;
  localparam logic [7:0]  STABLE_VALUE  = 8'h02;
  localparam logic [7:0]  WEIGHT_OFFSET = 8'h68;
  localparam logic [7:0]  MIN_LENGTH    = 8'd10;
  localparam logic [31:0] SETTLE_RESET  = 32'd2000;
  localparam int          QUEUE_DEPTH   = 2;

  typedef enum logic [2:0] {
    ST_IGNORED  = 3'd0,
    ST_ZERO     = 3'd1,
    ST_WAITING  = 3'd2,
    ST_REPORTED = 3'd3,
    ST_ALREADY  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CLS_IGNORE = 2'd0,
    CLS_ZERO   = 2'd1,
    CLS_MEAS   = 2'd2
  } cls_t;

  typedef struct packed {
    logic [7:0]  pkt_length;
    logic [7:0]  magic_byte;
    logic [7:0]  weight_top;
    logic [7:0]  weight_mid;
    logic [7:0]  weight_low;
    logic [7:0]  status_byte;
    logic [7:0]  imp_high;
    logic [7:0]  imp_low;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] weight_grams;
    logic [15:0] impedance;
  } out_item_t;

  // One classified packet as it waits between the front and the back.
  typedef struct packed {
    cls_t        cls;
    logic [23:0] weight;
    logic        stable;
    logic [15:0] imp;
    logic [31:0] now_ms;
  } q_entry_t;

endpackage

FILE: rtl/scale_packet_settle_latch_core.sv
// Top level of the scale packet settle latch.
// Depends on sps_pkg, sps_front, sps_queue and sps_back.
//
// Takes one decoded scale packet per transaction and returns exactly one result
// per packet, in order. A packet may be accepted every clock cycle unless in_stall
// is high; each packet passes through the queue and then the result register on
// its way to the output. The queue between the classifier and the settle logic
// holds QUEUE_DEPTH packets, so the input stalls only when a stalled output has
// backed the queue up. The settle time register is written through the cfg_
// port, which is always ready; write it only while no packet is in flight.
module scale_packet_settle_latch_core #(
  parameter int QUEUE_DEPTH = sps_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sps_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sps_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);

  sps_pkg::q_entry_t front_entry;
  sps_pkg::q_entry_t q_data;
  logic              q_full;
  logic              q_empty;
  logic              q_rd;

  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;

  sps_front u_front (
    .in_data (in_data),
    .entry   (front_entry)
  );

  sps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_valid && !q_full),
    .wr_data (front_entry),
    .full    (q_full),
    .rd_en   (q_rd),
    .empty   (q_empty),
    .rd_data (q_data)
  );

  sps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_rd      (q_rd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/sps_front.sv
// Front end: accepts packets and classifies them into queue entries.
// Depends on sps_pkg.
module sps_front (
  input  sps_pkg::in_item_t in_data,
  output sps_pkg::q_entry_t entry
);

  logic [7:0]  top_off;
  logic        neg;
  logic [23:0] weight;

  always_comb begin
    top_off = in_data.weight_top - sps_pkg::WEIGHT_OFFSET;
    neg     = (in_data.weight_top < sps_pkg::WEIGHT_OFFSET);
    // A top byte below the offset would give a negative weight; it clamps to zero.
    weight  = neg ? 24'd0 : {top_off, in_data.weight_mid, in_data.weight_low};

    entry.weight = weight;
    entry.stable = (in_data.status_byte == sps_pkg::STABLE_VALUE);
    entry.imp    = {in_data.imp_high, in_data.imp_low};
    entry.now_ms = in_data.now_ms;
    if ((in_data.pkt_length < sps_pkg::MIN_LENGTH) ||
        (in_data.magic_byte != sps_pkg::MAGIC_VALUE)) begin
      entry.cls = sps_pkg::CLS_IGNORE;
    end else if (weight == 24'd0) begin
      entry.cls = sps_pkg::CLS_ZERO;
    end else begin
      entry.cls = sps_pkg::CLS_MEAS;
    end
  end

endmodule

FILE: rtl/sps_queue.sv
// Short queue between the classifying front end and the state back end.
// Depends on sps_pkg.
module sps_queue #(
  parameter int DEPTH = sps_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  sps_pkg::q_entry_t wr_data,
  output logic              full,
  input  logic              rd_en,
  output logic              empty,
  output sps_pkg::q_entry_t rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sps_pkg::q_entry_t slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots_r[wr_ptr_r] <= wr_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full && !rd_en |-> !wr_en)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !rd_en)
    else $error("queue read while empty");

endmodule

FILE: rtl/sps_back.sv
// Back end: settle state, timer compare and the registered result stage.
// Depends on sps_pkg.
module sps_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_data,
  input  logic                q_empty,
  input  sps_pkg::q_entry_t   q_data,
  output logic                q_rd,
  output logic                out_valid,
  input  logic                out_stall,
  output sps_pkg::out_item_t  out_data
);

  logic [31:0] settle_r;
  logic        pend_valid_r, pend_valid_nxt;
  logic [23:0] pend_weight_r, pend_weight_nxt;
  logic [31:0] since_r, since_nxt;
  logic        sent_r, sent_nxt;
  logic        ovalid_r, ovalid_nxt;
  sps_pkg::out_item_t odata_r, odata_nxt;
  logic [31:0] elapsed;
  logic        same_weight;

  // A transaction leaves the queue whenever the result register is free or draining.
  assign q_rd      = !q_empty && (!ovalid_r || !out_stall);
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  assign elapsed     = q_data.now_ms - since_r;
  assign same_weight = pend_valid_r && (q_data.weight == pend_weight_r);

  always_comb begin
    pend_valid_nxt  = pend_valid_r;
    pend_weight_nxt = pend_weight_r;
    since_nxt       = since_r;
    sent_nxt        = sent_r;
    ovalid_nxt      = ovalid_r && out_stall;
    odata_nxt       = odata_r;
    if (q_rd) begin
      ovalid_nxt             = 1'b1;
      odata_nxt.weight_grams = '0;
      odata_nxt.impedance    = '0;
      case (q_data.cls)
        sps_pkg::CLS_IGNORE: begin
          odata_nxt.status = sps_pkg::ST_IGNORED;
        end
        sps_pkg::CLS_ZERO: begin
          pend_valid_nxt   = 1'b0;
          sent_nxt         = 1'b0;
          odata_nxt.status = sps_pkg::ST_ZERO;
        end
        sps_pkg::CLS_MEAS: begin
          if (sent_r) begin
            odata_nxt.status = sps_pkg::ST_ALREADY;
          end else if (!same_weight) begin
            pend_valid_nxt   = 1'b1;
            pend_weight_nxt  = q_data.weight;
            since_nxt        = q_data.now_ms;
            odata_nxt.status = sps_pkg::ST_WAITING;
          end else if (q_data.stable && (elapsed >= settle_r)) begin
            sent_nxt               = 1'b1;
            odata_nxt.status       = sps_pkg::ST_REPORTED;
            odata_nxt.weight_grams = pend_weight_r;
            odata_nxt.impedance    = q_data.imp;
          end else begin
            odata_nxt.status = sps_pkg::ST_WAITING;
          end
        end
        default: begin
          odata_nxt.status = sps_pkg::ST_IGNORED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r      <= sps_pkg::SETTLE_RESET;
      pend_valid_r  <= 1'b0;
      pend_weight_r <= '0;
      since_r       <= '0;
      sent_r        <= 1'b0;
      ovalid_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        settle_r <= cfg_data;
      end
      pend_valid_r  <= pend_valid_nxt;
      pend_weight_r <= pend_weight_nxt;
      since_r       <= since_nxt;
      sent_r        <= sent_nxt;
      ovalid_r      <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    odata_r <= odata_nxt;
  end

  a_report_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && (odata_r.status == sps_pkg::ST_REPORTED) |-> odata_r.weight_grams != 24'd0)
    else $error("report with zero weight");

  a_report_latches: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd && (odata_nxt.status == sps_pkg::ST_REPORTED) |=> sent_r)
    else $error("report did not set the sent mark");

  a_sent_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    sent_r |-> pend_valid_r)
    else $error("sent mark without pending weight");

endmodule

FILE: sim/tb.sv
// Self-checking testbench for scale_packet_settle_latch_core: drives scale packets,
// predicts each result in step with the block and compares every field.
// Depends on sps_pkg and the RTL in rtl/.
`timescale 1ns / 1ps

module tb;

  localparam int CLK_HALF_NS  = 2;
  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int TAIL_CYCLES  = 10;
  localparam int RUN_LIMIT_NS = 2_000_000;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  sps_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  sps_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [31:0]        cfg_data  = '0;

  scale_packet_settle_latch_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #(CLK_HALF_NS) clk = 1'b1;
    #(CLK_HALF_NS) clk = 1'b0;
  end

  sps_pkg::in_item_t  packet_backlog[$];
  sps_pkg::out_item_t settle_outcomes[$];
  int          mismatches     = 0;
  int          counted_packets = 0;
  int          send_idle_pct  = 34;
  int          recv_idle_pct  = 75;
  logic [31:0] scale_clock_ms = '0;

  // Predictor state, mirroring the latch inside the block.
  logic [31:0] mdl_settle_ms = sps_pkg::SETTLE_RESET;
  logic        mdl_pending   = 1'b0;
  logic [23:0] mdl_weight    = '0;
  logic [15:0] mdl_imp       = '0;
  logic        mdl_stable    = 1'b0;
  logic        mdl_sent      = 1'b0;
  logic [31:0] mdl_since     = '0;

  function automatic sps_pkg::out_item_t settle_outcome(input sps_pkg::in_item_t p);
    sps_pkg::out_item_t r;
    logic [23:0] grams;
    logic        steady;
    logic [31:0] elapsed;
    r = '0;
    r.status = sps_pkg::ST_IGNORED;
    if (p.pkt_length < sps_pkg::MIN_LENGTH || p.magic_byte != sps_pkg::MAGIC_VALUE) return r;
    // A top byte under the offset would make the weight negative; it reads as empty.
    grams = (p.weight_top < sps_pkg::WEIGHT_OFFSET) ? 24'd0 :
            {p.weight_top - sps_pkg::WEIGHT_OFFSET, p.weight_mid, p.weight_low};
    steady = (p.status_byte == sps_pkg::STABLE_VALUE);
    if (grams == 24'd0) begin
      mdl_pending = 1'b0;
      mdl_stable  = 1'b0;
      mdl_sent    = 1'b0;
      r.status    = sps_pkg::ST_ZERO;
    end else if (mdl_sent) begin
      r.status = sps_pkg::ST_ALREADY;
    end else if (!mdl_pending || grams != mdl_weight) begin
      mdl_pending = 1'b1;
      mdl_weight  = grams;
      mdl_imp     = {p.imp_high, p.imp_low};
      mdl_stable  = steady;
      mdl_since   = p.now_ms;
      r.status    = sps_pkg::ST_WAITING;
    end else begin
      mdl_imp    = {p.imp_high, p.imp_low};
      mdl_stable = steady;
      elapsed    = p.now_ms - mdl_since;
      if (mdl_stable && elapsed >= mdl_settle_ms) begin
        mdl_sent       = 1'b1;
        r.status       = sps_pkg::ST_REPORTED;
        r.weight_grams = mdl_weight;
        r.impedance    = mdl_imp;
      end else begin
        r.status = sps_pkg::ST_WAITING;
      end
    end
    return r;
  endfunction

  // Driver: a stalled transaction holds; otherwise the next packet may go out.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) settle_outcomes.push_back(settle_outcome(in_data));
      if (!in_valid || !in_stall) begin
        if (packet_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= packet_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic compare_field(input string what, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %h actual %h", $time, what, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    sps_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (settle_outcomes.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, out_data);
        mismatches++;
      end else begin
        want = settle_outcomes.pop_front();
        compare_field("status", 32'(want.status), 32'(out_data.status));
        compare_field("weight_grams", 32'(want.weight_grams), 32'(out_data.weight_grams));
        compare_field("impedance", 32'(want.impedance), 32'(out_data.impedance));
      end
    end
  end

  task automatic enqueue(input sps_pkg::in_item_t p);
    packet_backlog.push_back(p);
    if (p.pkt_length >= sps_pkg::MIN_LENGTH && p.magic_byte == sps_pkg::MAGIC_VALUE)
      counted_packets++;
  endtask

  function automatic sps_pkg::in_item_t scale_reading(input logic [23:0] raw,
                                                      input logic [7:0] stat,
                                                      input logic [15:0] imp,
                                                      input logic [31:0] now);
    sps_pkg::in_item_t p;
    p.pkt_length  = 8'($urandom_range(sps_pkg::MIN_LENGTH, 255));
    p.magic_byte  = sps_pkg::MAGIC_VALUE;
    p.weight_top  = raw[23:16];
    p.weight_mid  = raw[15:8];
    p.weight_low  = raw[7:0];
    p.status_byte = stat;
    p.imp_high    = imp[15:8];
    p.imp_low     = imp[7:0];
    p.now_ms      = now;
    return p;
  endfunction

  // Time between packets is scaled to the settle time, with occasional wild jumps.
  function automatic logic [31:0] tick_clock();
    logic [31:0] span;
    span = mdl_settle_ms / 2 + 2;
    case ($urandom_range(9))
      0: ;
      1: scale_clock_ms += mdl_settle_ms;
      2: scale_clock_ms += mdl_settle_ms - 1;
      3: scale_clock_ms += $urandom;
      default: scale_clock_ms += $urandom_range(0, span);
    endcase
    return scale_clock_ms;
  endfunction

  function automatic sps_pkg::in_item_t weighed_packet(input logic [23:0] raw,
                                                       input logic [7:0] stat);
    return scale_reading(raw, stat, 16'($urandom), tick_clock());
  endfunction

  function automatic logic [23:0] random_load();
    logic [23:0] raw;
    raw = {8'($urandom_range(sps_pkg::WEIGHT_OFFSET, 255)), 16'($urandom)};
    if (raw == {sps_pkg::WEIGHT_OFFSET, 16'h0000}) raw[0] = 1'b1;
    return raw;
  endfunction

  function automatic logic [23:0] empty_pan();
    if ($urandom_range(1)) return {sps_pkg::WEIGHT_OFFSET, 16'h0000};
    return {8'($urandom_range(0, sps_pkg::WEIGHT_OFFSET - 1)), 16'($urandom)};
  endfunction

  function automatic logic [7:0] stable_mostly();
    if ($urandom_range(9) < 8) return sps_pkg::STABLE_VALUE;
    return 8'($urandom);
  endfunction

  function automatic sps_pkg::in_item_t junk_packet();
    sps_pkg::in_item_t p;
    p = {$urandom, $urandom, $urandom};
    if ($urandom_range(1)) p.pkt_length = 8'($urandom_range(0, sps_pkg::MIN_LENGTH - 1));
    else if (p.magic_byte == sps_pkg::MAGIC_VALUE) p.magic_byte ^= 8'h01;
    return p;
  endfunction

  task automatic queue_scale_traffic(input int count);
    int                target;
    logic [23:0]       load;
    sps_pkg::in_item_t p;
    target = counted_packets + count;
    while (counted_packets < target) begin
      case ($urandom_range(9))
        7, 8: enqueue(junk_packet());
        9: begin
          p = {$urandom, $urandom, $urandom};
          if ($urandom_range(1)) begin
            p.magic_byte = sps_pkg::MAGIC_VALUE;
            p.pkt_length = 8'($urandom_range(sps_pkg::MIN_LENGTH, 255));
          end
          enqueue(p);
        end
        default: begin
          // A weighing: some fluctuating readings, then one load held for two to ten
          // readings, and usually the pan emptied at the end.
          repeat ($urandom_range(0, 3)) enqueue(weighed_packet(random_load(), 8'($urandom)));
          load = random_load();
          repeat ($urandom_range(2, 10)) begin
            if ($urandom_range(9) == 0) enqueue(junk_packet());
            enqueue(weighed_packet(load, stable_mostly()));
          end
          if ($urandom_range(9) < 7) enqueue(weighed_packet(empty_pan(), 8'($urandom)));
        end
      endcase
    end
  endtask

  task automatic wait_quiet();
    int n;
    n = 0;
    @(negedge clk);
    while (packet_backlog.size() != 0 || in_valid) @(negedge clk);
    while (settle_outcomes.size() != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic write_settle(input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mdl_settle_ms = value;
    @(negedge clk);
  endtask

  initial begin
    sps_pkg::in_item_t p;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Framing: short packets and a wrong magic byte are reported as ignored.
    p = scale_reading(24'h680001, sps_pkg::STABLE_VALUE, 16'h1234, 32'd50);
    p.pkt_length = 8'd9;
    enqueue(p);
    p.pkt_length = 8'd0;
    enqueue(p);
    p.pkt_length = 8'd255;
    p.magic_byte = 8'hAB;
    enqueue(p);
    // Negative weight clamps to empty, as does an exact zero.
    enqueue(scale_reading(24'h67FFFF, sps_pkg::STABLE_VALUE, 16'h0000, 32'd60));
    enqueue(scale_reading(24'h680000, sps_pkg::STABLE_VALUE, 16'hFFFF, 32'd100));
    // One gram: unstable start, one short of the settle time, unstable, then exact.
    enqueue(scale_reading(24'h680001, 8'h00, 16'h0001, 32'd100));
    enqueue(scale_reading(24'h680001, sps_pkg::STABLE_VALUE, 16'h0002, 32'd2099));
    enqueue(scale_reading(24'h680001, 8'h03, 16'h0003, 32'd5100));
    enqueue(scale_reading(24'h680001, sps_pkg::STABLE_VALUE, 16'hFFFF, 32'd2100));
    enqueue(scale_reading(24'h680001, sps_pkg::STABLE_VALUE, 16'h0000, 32'd2200));
    enqueue(scale_reading(24'h9ABCDE, sps_pkg::STABLE_VALUE, 16'h0000, 32'd9000));
    enqueue(scale_reading(24'h000000, 8'hFF, 16'hFFFF, 32'd9001));
    // Full-scale load settling across the timer wrap.
    enqueue(scale_reading(24'hFFFFFF, sps_pkg::STABLE_VALUE, 16'h0000, 32'hFFFF_FF00));
    enqueue(scale_reading(24'hFFFFFF, sps_pkg::STABLE_VALUE, 16'h0000, 32'h0000_06D0));
    enqueue(scale_reading(24'h010203, sps_pkg::STABLE_VALUE, 16'h0000, 32'd1));
    // A changed weight restarts the timer.
    enqueue(scale_reading(24'h800000, sps_pkg::STABLE_VALUE, 16'hA5A5, 32'd0));
    enqueue(scale_reading(24'h800001, sps_pkg::STABLE_VALUE, 16'h5A5A, 32'd10000));
    enqueue(scale_reading(24'h800001, sps_pkg::STABLE_VALUE, 16'h5A5A, 32'd11999));
    enqueue(scale_reading(24'h800001, sps_pkg::STABLE_VALUE, 16'h5A5A, 32'd12000));
    enqueue(scale_reading(24'h680000, sps_pkg::STABLE_VALUE, 16'h0000, 32'd12001));
    scale_clock_ms = 32'd12001;
    wait_quiet();

    // With no settle time a stable repeat reports at once.
    write_settle(32'd0);
    enqueue(scale_reading(24'hC00000, sps_pkg::STABLE_VALUE, 16'h0101, 32'd500));
    enqueue(scale_reading(24'hC00000, sps_pkg::STABLE_VALUE, 16'h0202, 32'd500));
    enqueue(scale_reading(24'h000000, 8'h00, 16'h0000, 32'd501));
    queue_scale_traffic(250);
    wait_quiet();

    // The longest settle time is met only one tick before the timer comes round.
    write_settle(32'hFFFF_FFFF);
    enqueue(scale_reading(24'hC00000, sps_pkg::STABLE_VALUE, 16'h0001, 32'h0000_1000));
    enqueue(scale_reading(24'hC00000, sps_pkg::STABLE_VALUE, 16'h0002, 32'h0000_0FFE));
    enqueue(scale_reading(24'hC00000, sps_pkg::STABLE_VALUE, 16'h0003, 32'h0000_0FFF));
    enqueue(scale_reading(24'h000000, 8'h00, 16'h0000, 32'h0000_1001));
    queue_scale_traffic(250);
    wait_quiet();

    send_idle_pct = 75;
    recv_idle_pct = 34;
    write_settle(32'd1);
    queue_scale_traffic(250);
    wait_quiet();
    write_settle($urandom_range(2, 5000));
    queue_scale_traffic(250);
    wait_quiet();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_settle(sps_pkg::SETTLE_RESET);
    queue_scale_traffic(250);
    wait_quiet();
    write_settle($urandom);
    queue_scale_traffic(250);
    wait_quiet();

    if (settle_outcomes.size() != 0) begin
      $display("%0t: %0d results expected but never seen", $time, settle_outcomes.size());
      mismatches += settle_outcomes.size();
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: sim.f
rtl/sps_pkg.sv
rtl/sps_front.sv
rtl/sps_queue.sv
rtl/sps_back.sv
rtl/scale_packet_settle_latch_core.sv
sim/tb.sv
